[sv/dmx_pkg.sv]
package dmx_pkg;

   // Field and register widths
   localparam int SAMPLE_W = 32;
   localparam int WIDTH_CODE_W = 2;
   localparam int COUNT_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam int SHIFT_W = 5;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'd1;

   // Sample width codes
   localparam logic [WIDTH_CODE_W-1:0] WIDTH_8 = 2'd0;
   localparam logic [WIDTH_CODE_W-1:0] WIDTH_16 = 2'd1;
   localparam logic [WIDTH_CODE_W-1:0] WIDTH_24 = 2'd2;
   localparam logic [WIDTH_CODE_W-1:0] WIDTH_32 = 2'd3;

   // Reset values of the registers
   localparam logic [WIDTH_CODE_W-1:0] WIDTH_CODE_RESET = WIDTH_16;
   localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

   // Frame position flags handed to the mix unit
   typedef struct packed {
      logic first;
      logic last;
   } frame_flags_type;

   // Left shift that brings a sample of the given width up to Q1.31
   function automatic logic [SHIFT_W-1:0] justify_shift(input logic [WIDTH_CODE_W-1:0] code);
      logic [SHIFT_W-1:0] shift;
      case (code)
         WIDTH_8:  shift = 5'd24;
         WIDTH_16: shift = 5'd16;
         WIDTH_24: shift = 5'd8;
         WIDTH_32: shift = 5'd0;
         default:  shift = 5'd0;
      endcase
      return shift;
   endfunction

endpackage

[sv/pcm_channel_downmixer_core.sv]
// The last channel of a frame loads the input register, and its mix loads the result register
// (which drives rsp_tvalid) once that register is free. Throughput: one sample per cycle,
// but a last channel waits while the result register is full; the accumulator update (one
// 32x32 multiply, add and clamp) sits in a single stage behind the input register.
// Reset (synchronous, active high) empties both registers, clears the accumulator and
// frame position, and sets the width to 16 bits and the channel count to 2.
module pcm_channel_downmixer_core #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input samples
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dmx_pkg::SAMPLE_W-1:0]   req_tdata,   // [31:0] sample_value
   // Mixed output
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dmx_pkg::SAMPLE_W-1:0]   rsp_tdata,   // [31:0] mixed_value
   // Register writes
   input  logic                           csr_wr_en,
   input  logic [dmx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dmx_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   logic [dmx_pkg::WIDTH_CODE_W-1:0] width_code_ff;
   logic [dmx_pkg::COUNT_W-1:0]      count_ff;
   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic [dmx_pkg::SAMPLE_W-1:0]     s1_sample_ff;
   logic [dmx_pkg::SAMPLE_W-1:0]     acc_ff;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic [dmx_pkg::SAMPLE_W-1:0]     out_data_ff;
   logic [dmx_pkg::SAMPLE_W-1:0]     acc_next;
   logic [dmx_pkg::SAMPLE_W-1:0]     mixed;
   dmx_pkg::frame_flags_type         flags;
   logic                             out_free;
   logic                             s1_advance;
   logic                             req_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_code_ff <= dmx_pkg::WIDTH_CODE_RESET;
         count_ff <= dmx_pkg::CHANNEL_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dmx_pkg::CSR_SAMPLE_WIDTH:
               width_code_ff <= csr_wr_data[dmx_pkg::WIDTH_CODE_W-1:0];
            dmx_pkg::CSR_CHANNEL_COUNT:
               count_ff <= csr_wr_data[dmx_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: a sample that yields no output always moves on
   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!flags.last || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take = req_tvalid && req_tready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);
   assign out_valid_in = (s1_advance && flags.last) || (out_valid_ff && !rsp_tready);

   // Frame position tracking
   dmx_frame_ctrl #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_frame_ctrl (
      .clock(clock),
      .reset(reset),
      .advance(s1_advance),
      .channel_count(count_ff),
      .flags(flags)
   );

   // Mixing datapath
   dmx_mix_unit u_mix_unit (
      .sample(s1_sample_ff),
      .acc(acc_ff),
      .width_code(width_code_ff),
      .flags(flags),
      .acc_next(acc_next),
      .mixed(mixed)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_advance) begin
            acc_ff <= acc_next;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_tdata;
      end
      if (s1_advance && flags.last) begin
         out_data_ff <= mixed;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   // A last channel that moves on always lands in the result register
   a_last_loads_out: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && flags.last) |=> out_valid_ff)
      else $error("last channel did not produce an output transaction");

   // A new result only appears from a finished frame
   a_out_from_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff && flags.last))
      else $error("output transaction without a completed frame");

   // A last channel blocked by a full result register holds its sample
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && flags.last && out_valid_ff && !rsp_tready)
         |=> (s1_valid_ff && $stable(s1_sample_ff)))
      else $error("stalled sample was lost");

endmodule

[sv/dmx_mix_unit.sv]
module dmx_mix_unit (
   input  logic [dmx_pkg::SAMPLE_W-1:0]     sample,
   input  logic [dmx_pkg::SAMPLE_W-1:0]     acc,
   input  logic [dmx_pkg::WIDTH_CODE_W-1:0] width_code,
   input  dmx_pkg::frame_flags_type         flags,
   output logic [dmx_pkg::SAMPLE_W-1:0]     acc_next,
   output logic [dmx_pkg::SAMPLE_W-1:0]     mixed
);

   localparam int SUM_W = dmx_pkg::SAMPLE_W + 2;
   localparam int PROD_W = 2 * dmx_pkg::SAMPLE_W;

   logic [dmx_pkg::SHIFT_W-1:0]  shift;
   logic signed [dmx_pkg::SAMPLE_W-1:0] a_s;
   logic signed [dmx_pkg::SAMPLE_W-1:0] b_s;
   logic signed [PROD_W-1:0]     prod;
   logic signed [SUM_W-1:0]      prod_q31;
   logic signed [SUM_W-1:0]      sum;
   logic signed [SUM_W-1:0]      mix;
   logic                         both_neg;
   logic                         both_pos;
   logic [dmx_pkg::SAMPLE_W-1:0] sat;

   // Left-justify the new sample to Q1.31
   assign shift = dmx_pkg::justify_shift(width_code);
   assign b_s = $signed(sample << shift);
   assign a_s = $signed(acc);

   // Product scaled back to Q1.31, floored (arithmetic shift)
   assign prod = a_s * b_s;
   assign prod_q31 = SUM_W'(prod[PROD_W-1:dmx_pkg::SAMPLE_W-1]);

   assign both_neg = a_s[dmx_pkg::SAMPLE_W-1] & b_s[dmx_pkg::SAMPLE_W-1];
   assign both_pos = !a_s[dmx_pkg::SAMPLE_W-1] && (a_s != '0)
                  && !b_s[dmx_pkg::SAMPLE_W-1] && (b_s != '0);

   // Combine a+b, pulled toward zero by the product on same-sign inputs
   always_comb begin
      sum = SUM_W'(a_s) + SUM_W'(b_s);
      if (both_neg) begin
         mix = sum + prod_q31;
      end else if (both_pos) begin
         mix = sum - prod_q31;
      end else begin
         mix = sum;
      end
   end

   // Clamp to the Q1.31 range
   always_comb begin
      if (mix > SUM_W'(33'sh0_7FFF_FFFF)) begin
         sat = 32'h7FFF_FFFF;
      end else if (mix < -SUM_W'(33'sh0_8000_0000)) begin
         sat = 32'h8000_0000;
      end else begin
         sat = mix[dmx_pkg::SAMPLE_W-1:0];
      end
   end

   // First channel seeds the accumulator
   assign acc_next = flags.first ? b_s : sat;

   // Shift back to the sample width, sign-extended
   assign mixed = $signed(acc_next) >>> shift;

endmodule

[sv/dmx_frame_ctrl.sv]
module dmx_frame_ctrl #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [dmx_pkg::COUNT_W-1:0] channel_count,
   output dmx_pkg::frame_flags_type    flags
);

   localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W = POS_W + dmx_pkg::COUNT_W + 1;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [CMP_W-1:0] count_raw;
   logic [CMP_W-1:0] count_eff;

   // Clamp the channel count to one through MAX_CHANNELS
   always_comb begin
      count_raw = CMP_W'(channel_count);
      if (count_raw == '0) begin
         count_eff = CMP_W'(1);
      end else if (count_raw > CMP_W'(MAX_CHANNELS)) begin
         count_eff = CMP_W'(MAX_CHANNELS);
      end else begin
         count_eff = count_raw;
      end
   end

   assign flags.first = (pos_ff == '0);
   assign flags.last = ((CMP_W'(pos_ff) + CMP_W'(1)) >= count_eff);

   // Advance the position, wrap at the end of a frame
   always_comb begin
      pos_in = pos_ff;
      if (advance) begin
         pos_in = flags.last ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

[tb/sv/testbench.sv]
module testbench;

   localparam int MIX_MAX_CHANNELS = 8;
   localparam int DRAIN_CYCLES = 4;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 1830;
   localparam int NUM_ROWS = 32;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic [dmx_pkg::CSR_INDEX_W-1:0]    csr_idx;
      logic [dmx_pkg::CSR_DATA_W-1:0]     csr_data;
      logic [dmx_pkg::SAMPLE_W-1:0]       sample;
      logic                               has_mix;
      logic [dmx_pkg::SAMPLE_W-1:0]       known_mix;
   } stim_row_type;

   // Directed frames: full scale, mixed signs, saturation, pass-through,
   // out-of-range counts, stray upper bits and a register change mid-frame
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_7FFF, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_7FFF, 1'b1, 32'h0000_7FFF},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'hFFFF_8000, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'hFFFF_8000, 1'b1, 32'hFFFF_8000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_7FFF, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'hFFFF_8000, 1'b1, 32'hFFFF_FFFF},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'hABCD_1234, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h5555_ED00, 1'b0, 32'h0000_0000},
      '{ROW_WRITE,  dmx_pkg::CSR_SAMPLE_WIDTH,  {2'b11, dmx_pkg::WIDTH_32}, 32'h0, 1'b0, 32'h0},
      '{ROW_WRITE,  dmx_pkg::CSR_CHANNEL_COUNT, 4'd1, 32'h0, 1'b0, 32'h0},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_WRITE,  dmx_pkg::CSR_CHANNEL_COUNT, 4'd2, 32'h0, 1'b0, 32'h0},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_WRITE,  dmx_pkg::CSR_SAMPLE_WIDTH,  {2'b00, dmx_pkg::WIDTH_8}, 32'h0, 1'b0, 32'h0},
      '{ROW_WRITE,  dmx_pkg::CSR_CHANNEL_COUNT, 4'd0, 32'h0, 1'b0, 32'h0},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'hFFFF_FF80, 1'b1, 32'hFFFF_FF80},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_017F, 1'b1, 32'h0000_007F},
      '{ROW_WRITE,  dmx_pkg::CSR_SAMPLE_WIDTH,  {2'b01, dmx_pkg::WIDTH_24}, 32'h0, 1'b0, 32'h0},
      '{ROW_WRITE,  dmx_pkg::CSR_CHANNEL_COUNT, 4'd15, 32'h0, 1'b0, 32'h0},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h007F_FFFF, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'hFF80_0000, 1'b0, 32'h0000_0000},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0012_3456, 1'b0, 32'h0000_0000},
      '{ROW_WRITE,  dmx_pkg::CSR_SAMPLE_WIDTH,  {2'b00, dmx_pkg::WIDTH_16}, 32'h0, 1'b0, 32'h0},
      '{ROW_WRITE,  dmx_pkg::CSR_CHANNEL_COUNT, 4'd2, 32'h0, 1'b0, 32'h0},
      '{ROW_SAMPLE, dmx_pkg::CSR_SAMPLE_WIDTH,  4'h0, 32'h0000_ABCD, 1'b0, 32'h0000_0000}
   };

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dmx_pkg::SAMPLE_W-1:0]    req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dmx_pkg::SAMPLE_W-1:0]    rsp_tdata;
   logic                            csr_wr_en;
   logic [dmx_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dmx_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   // Predictor state
   logic [dmx_pkg::WIDTH_CODE_W-1:0] mix_width;
   logic [dmx_pkg::COUNT_W-1:0]      mix_count;
   logic [31:0]                      mix_acc;
   logic [2:0]                       mix_pos;

   logic [dmx_pkg::SAMPLE_W-1:0] expected_mix [$];
   int                           mismatch_count = 0;
   int                           quiet_cycles = 0;
   bit                           tx_calm = 1'b0;
   bit                           rx_calm = 1'b0;

   pcm_channel_downmixer_core #(
      .MAX_CHANNELS(MIX_MAX_CHANNELS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Fold one channel into the running mix; flag and return the mono sample
   // when the channel closes its frame
   function automatic void fold_sample(input logic [31:0] sample, output bit done,
                                       output logic [31:0] mixed);
      int unsigned shift;
      int unsigned count;
      logic [31:0] left;
      longint a;
      longint b;
      longint m;
      longint p;
      shift = 24 - 8 * int'(mix_width);
      count = mix_count;
      if (count < 1) count = 1;
      if (count > MIX_MAX_CHANNELS) count = MIX_MAX_CHANNELS;
      left = sample << shift;
      b = longint'(signed'(left));
      if (mix_pos == 3'd0) begin
         m = b;
      end else begin
         a = longint'(signed'(mix_acc));
         m = a + b;
         p = (a * b) >>> 31;
         if (a < 0 && b < 0) m = m + p;
         else if (a > 0 && b > 0) m = m - p;
         if (m > 64'sh7FFF_FFFF) m = 64'sh7FFF_FFFF;
         if (m < -64'sh8000_0000) m = -64'sh8000_0000;
      end
      mix_acc = m[31:0];
      mixed = '0;
      if (int'(mix_pos) + 1 >= count) begin
         mix_pos = 3'd0;
         mixed = $signed(mix_acc) >>> shift;
         done = 1'b1;
      end else begin
         mix_pos = mix_pos + 3'd1;
         done = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("MISMATCH %s: got %h expected %h", what, got, want);
   endtask

   // Offer one sample, hold it until accepted, then predict its result
   task automatic send_sample(input logic [31:0] value, input bit has_mix,
                              input logic [31:0] known_mix);
      int gap;
      bit done;
      logic [31:0] mixed;
      gap = tx_calm ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      fold_sample(value, done, mixed);
      if (done) expected_mix.push_back(has_mix ? known_mix : mixed);
   endtask

   task automatic csr_write(input logic [dmx_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dmx_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == dmx_pkg::CSR_SAMPLE_WIDTH) mix_width = data[dmx_pkg::WIDTH_CODE_W-1:0];
      else mix_count = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drop valid, drain every expected mix, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_mix.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stall before each transaction, ready held until taken
   initial begin : mix_sink
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = rx_calm ? 0 : $urandom_range(0, 11);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check each mix transaction and watch for a stalled run
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_mix.size() == 0) begin
               report_mismatch("unexpected mixed_value", rsp_tdata, 'x);
            end else begin
               if (rsp_tdata !== expected_mix[0])
                  report_mismatch("mixed_value", rsp_tdata, expected_mix[0]);
               void'(expected_mix.pop_front());
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int sent;
      int phase_len;
      int nbits;
      logic [31:0] mask;
      logic [31:0] pick;
      logic [31:0] value;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      mix_width = dmx_pkg::WIDTH_CODE_RESET;
      mix_count = dmx_pkg::CHANNEL_COUNT_RESET;
      mix_acc = '0;
      mix_pos = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            csr_write(row.csr_idx, row.csr_data);
         end else begin
            send_sample(row.sample, row.has_mix, row.known_mix);
         end
      end

      // Random phases, each with possibly new settings and a fresh idling style
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         if ($urandom_range(0, 3) != 0)
            csr_write(dmx_pkg::CSR_SAMPLE_WIDTH,
                      dmx_pkg::CSR_DATA_W'($urandom_range(0, 15)));
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 9) < 7)
               csr_write(dmx_pkg::CSR_CHANNEL_COUNT,
                         dmx_pkg::CSR_DATA_W'($urandom_range(1, 8)));
            else
               csr_write(dmx_pkg::CSR_CHANNEL_COUNT,
                         dmx_pkg::CSR_DATA_W'($urandom_range(0, 15)));
         end
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(10, 80);
         nbits = 8 * (int'(mix_width) + 1);
         mask = 32'hFFFF_FFFF >> (32 - nbits);
         repeat (phase_len) begin
            case ($urandom_range(0, 9))
               5, 6, 7: begin
                  // full-scale corners at the current width, stray upper bits
                  case ($urandom_range(0, 4))
                     0: pick = mask >> 1;
                     1: pick = (mask >> 1) + 1;
                     2: pick = '0;
                     3: pick = mask;
                     default: pick = 32'd1;
                  endcase
                  value = ($urandom & ~mask) | (pick & mask);
               end
               8, 9: begin
                  // close to full scale, to push the mix toward its limits
                  if ($urandom_range(0, 1) == 1) pick = (mask >> 1) - $urandom_range(0, 255);
                  else pick = (mask >> 1) + 1 + $urandom_range(0, 255);
                  value = ($urandom & ~mask) | (pick & mask);
               end
               default: value = $urandom;
            endcase
            send_sample(value, 1'b0, '0);
            sent++;
         end
      end

      wait_idle();
      if (mismatch_count == 0 && expected_mix.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
